// ===== design/c32h_pkg.sv =====
package c32h_pkg;

  // reflected castagnoli polynomial and finishing multiplier
  localparam logic [31:0] CRC_POLY    = 32'h82F63B78;
  localparam logic [31:0] FINISH_MULT = 32'h805204f3;

  // byte length counter saturates at this value
  localparam logic [32:0] LEN_CAP    = 33'h1_0000_0000;
  localparam logic [2:0]  BYTES_FULL = 3'd4;

  // finished message handed from front to back
  typedef struct packed {
    logic [31:0] crc;
    logic [31:0] len_low;
    logic        too_long;
  } job_t;

  // fold of a single set bit through 32 shift steps (constant per bit)
  function automatic logic [31:0] fold_col(input int unsigned b);
    logic [31:0] c;
    c = 32'h1 << b;
    for (int k = 0; k < 32; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // 32-bit crc fold as a linear xor map: sum of constant columns
  function automatic logic [31:0] crc_fold32(input logic [31:0] x);
    logic [31:0] r;
    r = '0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) r = r ^ fold_col(i);
    end
    return r;
  endfunction

endpackage

// ===== design/crc32c_byte_string_hash.sv =====
// throughput: one beat per cycle unless the queue is full;
// the front crc fold and length count run each cycle
// results wait in a short queue and a four-stage back pipeline (fold, fold, multiply, mix)
// reset: synchronous, active high; clears crc, length, seed, queue and all valid bits
module crc32c_byte_string_hash #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        first_word,
  input  logic [31:0] seed,
  input  logic [31:0] data_word,
  input  logic [2:0]  byte_count,
  input  logic        last_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] hash_value,
  output logic        too_long
);

  logic           push, q_full, pop, q_valid;
  c32h_pkg::job_t push_job, pop_job;

  c32h_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .first_word (first_word),
    .seed       (seed),
    .data_word  (data_word),
    .byte_count (byte_count),
    .last_word  (last_word),
    .push       (push),
    .push_job   (push_job),
    .q_full     (q_full)
  );

  c32h_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .pop_job  (pop_job)
  );

  c32h_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .pop_job    (pop_job),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hash_value (hash_value),
    .too_long   (too_long)
  );

endmodule

// ===== design/c32h_front.sv =====
module c32h_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              first_word,
  input  logic [31:0]       seed,
  input  logic [31:0]       data_word,
  input  logic [2:0]        byte_count,
  input  logic              last_word,
  output logic              push,
  output c32h_pkg::job_t    push_job,
  input  logic              q_full
);

  logic [31:0] running_crc, running_crc_next;
  logic [32:0] message_length, message_length_next;
  logic [31:0] saved_seed, saved_seed_next;

  logic        accept;
  logic [31:0] base_crc, base_seed, keep, masked, fold_in, folded;
  logic [32:0] base_len, len_sat;
  logic [33:0] len_sum;
  logic [2:0]  cnt;
  logic        too;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // start of message takes the seed, otherwise carry on
  always_comb begin
    base_crc  = first_word ? seed  : running_crc;
    base_seed = first_word ? seed  : saved_seed;
    base_len  = first_word ? '0    : message_length;
  end

  // byte count of this beat and zero padding of a partial last word
  always_comb begin
    if (!last_word) begin
      cnt = c32h_pkg::BYTES_FULL;
    end else if (byte_count > c32h_pkg::BYTES_FULL) begin
      cnt = c32h_pkg::BYTES_FULL;
    end else begin
      cnt = byte_count;
    end
    unique case (cnt)
      3'd0:    keep = 32'h0000_0000;
      3'd1:    keep = 32'h0000_00FF;
      3'd2:    keep = 32'h0000_FFFF;
      3'd3:    keep = 32'h00FF_FFFF;
      default: keep = 32'hFFFF_FFFF;
    endcase
    masked  = data_word & keep;
    fold_in = base_crc ^ masked;
    folded  = (cnt == 3'd0) ? base_crc : c32h_pkg::crc_fold32(fold_in);
  end

  // saturating length
  always_comb begin
    len_sum = {1'b0, base_len} + 34'(cnt);
    len_sat = (len_sum > {1'b0, c32h_pkg::LEN_CAP}) ? c32h_pkg::LEN_CAP : len_sum[32:0];
    too     = len_sat[32];
  end

  // job for the back end
  always_comb begin
    push              = accept && last_word;
    push_job.too_long = too;
    push_job.crc      = too ? base_seed : folded;
    push_job.len_low  = too ? 32'h0 : len_sat[31:0];
  end

  // next state: cleared after a last beat
  always_comb begin
    running_crc_next    = running_crc;
    message_length_next = message_length;
    saved_seed_next     = saved_seed;
    if (accept) begin
      if (last_word) begin
        running_crc_next    = '0;
        message_length_next = '0;
        saved_seed_next     = '0;
      end else begin
        running_crc_next    = folded;
        message_length_next = len_sat;
        saved_seed_next     = base_seed;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc    <= '0;
      message_length <= '0;
      saved_seed     <= '0;
    end else begin
      running_crc    <= running_crc_next;
      message_length <= message_length_next;
      saved_seed     <= saved_seed_next;
    end
  end

  // state returns to zero after a message ends
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    accept && last_word |=> message_length == '0 && running_crc == '0)
    else $error("front state not cleared after last beat");

  // length never passes the cap
  a_len_capped: assert property (@(posedge clk) disable iff (rst)
    message_length <= c32h_pkg::LEN_CAP)
    else $error("message length above cap");

endmodule

// ===== design/c32h_queue.sv =====
module c32h_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  c32h_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output c32h_pkg::job_t pop_job
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  c32h_pkg::job_t    mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push, do_pop;

  assign full     = (count == CNT_FULL);
  assign q_valid  = (count != '0);
  assign pop_job  = mem[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && q_valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_job;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("push into full queue");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("queue count out of range");

endmodule

// ===== design/c32h_back.sv =====
module c32h_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  c32h_pkg::job_t pop_job,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [31:0]    hash_value,
  output logic           too_long
);

  logic        s1_v, s2_v, s3_v;
  logic [31:0] s1_crc, s2_crc, s3_prod;
  logic        s1_too, s2_too, s3_too;
  logic        out_free, s3_free, s2_free, s1_free;

  // stall chain from the output back
  always_comb begin
    out_free = !out_valid || out_ready;
    s3_free  = !s3_v || out_free;
    s2_free  = !s2_v || s3_free;
    s1_free  = !s1_v || s2_free;
    pop      = q_valid && s1_free;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      s3_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_free)  s1_v      <= q_valid;
      if (s2_free)  s2_v      <= s1_v;
      if (s3_free)  s3_v      <= s2_v;
      if (out_free) out_valid <= s3_v;
    end
  end

  // fold over length low word, then over the zero high word,
  // multiply, and mix the top half down
  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_crc <= c32h_pkg::crc_fold32(pop_job.crc ^ pop_job.len_low);
      s1_too <= pop_job.too_long;
    end
    if (s2_free) begin
      s2_crc <= c32h_pkg::crc_fold32(s1_crc);
      s2_too <= s1_too;
    end
    if (s3_free) begin
      s3_prod <= s2_crc * c32h_pkg::FINISH_MULT;
      s3_too  <= s2_too;
    end
    if (out_free) begin
      hash_value <= s3_prod ^ (s3_prod >> 16);
      too_long   <= s3_too;
    end
  end

  a_pop_when_free: assert property (@(posedge clk) disable iff (rst)
    pop |=> s1_v)
    else $error("popped beat not held in first stage");

endmodule

// ===== test/crc32c_byte_string_hash_tb.sv =====
module crc32c_byte_string_hash_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // own copies of the hash constants
  localparam logic [31:0] POLY_REFL   = 32'h82F63B78;
  localparam logic [31:0] MIX_FACTOR  = 32'h805204f3;
  localparam logic [32:0] BYTES_LIMIT = 33'h1_0000_0000;
  localparam int unsigned TARGET_BEATS = 1550;
  localparam int unsigned CALM_BEATS   = 1400;

  typedef struct {
    logic [31:0] hash;
    logic        overlong;
  } digest_t;

  // predictor of the running hash plus the queue of digests still owed
  class hash_scoreboard;
    logic [31:0] crc_acc;
    logic [32:0] byte_len;
    logic [31:0] seed_hold;
    digest_t     owed[$];
    int unsigned errors;

    function new();
      clear_state();
      errors = 0;
    endfunction

    function void clear_state();
      crc_acc   = '0;
      byte_len  = '0;
      seed_hold = '0;
    endfunction

    // one word through the reflected crc, bit by bit
    function logic [31:0] fold_word(logic [31:0] c, logic [31:0] w);
      c = c ^ w;
      for (int k = 0; k < 32; k++) begin
        c = c[0] ? ((c >> 1) ^ POLY_REFL) : (c >> 1);
      end
      return c;
    endfunction

    function logic [31:0] finish(logic [31:0] c, logic [32:0] n);
      logic [31:0] v;
      c = fold_word(c, n[31:0]);
      c = fold_word(c, {31'd0, n[32]});
      v = c * MIX_FACTOR;
      return v ^ (v >> 16);
    endfunction

    function logic [32:0] add_bytes(logic [32:0] n, int unsigned k);
      logic [33:0] sum;
      sum = {1'b0, n} + 34'(k);
      return (sum > {1'b0, BYTES_LIMIT}) ? BYTES_LIMIT : sum[32:0];
    endfunction

    // accepted input beat
    function void note_beat(logic first, logic [31:0] sd, logic [31:0] w,
                            logic [2:0] cnt, logic last);
      int unsigned nb;
      logic [31:0] keep;
      digest_t d;
      if (first) begin
        crc_acc   = sd;
        seed_hold = sd;
        byte_len  = '0;
      end
      if (!last) begin
        crc_acc  = fold_word(crc_acc, w);
        byte_len = add_bytes(byte_len, 4);
        return;
      end
      nb = (cnt > 3'd4) ? 4 : cnt;
      if (nb > 0) begin
        keep    = (nb == 4) ? 32'hFFFF_FFFF : ((32'd1 << (nb * 8)) - 32'd1);
        crc_acc = fold_word(crc_acc, w & keep);
      end
      byte_len = add_bytes(byte_len, nb);
      if (byte_len > 33'h0_FFFF_FFFF) begin
        d.hash     = finish(seed_hold, '0);
        d.overlong = 1'b1;
      end else begin
        d.hash     = finish(crc_acc, byte_len);
        d.overlong = 1'b0;
      end
      owed.push_back(d);
      clear_state();
    endfunction

    // accepted result beat against the oldest owed digest
    function void check_result(logic [31:0] h, logic ovl);
      digest_t d;
      if (owed.size() == 0) begin
        $display("%0t: result with nothing owed: hash %h too_long %b", $time, h, ovl);
        errors++;
        return;
      end
      d = owed.pop_front();
      if (h !== d.hash) begin
        $display("%0t: hash_value expected %h actual %h", $time, d.hash, h);
        errors++;
      end
      if (ovl !== d.overlong) begin
        $display("%0t: too_long expected %b actual %b", $time, d.overlong, ovl);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        first_word;
  logic [31:0] seed;
  logic [31:0] data_word;
  logic [2:0]  byte_count;
  logic        last_word;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] hash_value;
  logic        too_long;

  hash_scoreboard sb;
  int unsigned beats_sent;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  crc32c_byte_string_hash dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .first_word (first_word),
    .seed       (seed),
    .data_word  (data_word),
    .byte_count (byte_count),
    .last_word  (last_word),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hash_value (hash_value),
    .too_long   (too_long)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // bias towards all-zero and all-one words
  function automatic logic [31:0] pick_word();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return 32'h0;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // drive one input beat, with an optional idle burst in front
  task automatic send_beat(logic first, logic [31:0] sd, logic [31:0] w,
                           logic [2:0] cnt, logic last);
    int unsigned gap;
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, 14);
      @(negedge clk);
      in_valid   = 1'b0;
      first_word = 1'($urandom);
      seed       = $urandom;
      data_word  = $urandom;
      byte_count = 3'($urandom);
      last_word  = 1'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid   = 1'b1;
    first_word = first;
    seed       = sd;
    data_word  = w;
    byte_count = cnt;
    last_word  = last;
    do @(posedge clk); while (!in_ready);
    sb.note_beat(first, sd, w, cnt, last);
    beats_sent++;
  endtask

  // random message: mostly well formed, some without a first mark or restarted
  task automatic send_message();
    int unsigned pick, nwords;
    logic first, last;
    logic [2:0] cnt;
    pick   = $urandom_range(0, 99);
    nwords = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
    for (int unsigned i = 0; i < nwords; i++) begin
      if (i == 0) first = (pick < 88);
      else first = (pick >= 94) && ($urandom_range(0, 3) == 0);
      last = (i == nwords - 1);
      if (last) cnt = 3'(($urandom_range(0, 9) == 0) ? $urandom_range(5, 7)
                                                      : $urandom_range(0, 4));
      else cnt = 3'($urandom_range(0, 7));
      send_beat(first, pick_word(), pick_word(), cnt, last);
    end
  endtask

  // result side: random stall bursts
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 14) - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(hash_value, too_long);
  end

  // run limit
  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    int unsigned next_change;
    sb             = new();
    beats_sent     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst        = 1'b1;
    in_valid   = 1'b0;
    first_word = 1'b0;
    seed       = '0;
    data_word  = '0;
    byte_count = '0;
    last_word  = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty messages at both seed extremes
    send_beat(1'b1, 32'h0, 32'hFFFF_FFFF, 3'd0, 1'b1);
    send_beat(1'b1, 32'hFFFF_FFFF, 32'h1234_5678, 3'd0, 1'b1);
    // single word, each byte count, then counts above four
    send_beat(1'b1, 32'h0, 32'hFFFF_FFFF, 3'd1, 1'b1);
    send_beat(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd2, 1'b1);
    send_beat(1'b1, 32'hA5A5_5A5A, 32'hFFFF_FFFF, 3'd3, 1'b1);
    send_beat(1'b1, 32'h0, 32'h0, 3'd4, 1'b1);
    send_beat(1'b1, 32'h1, 32'hDEAD_BEEF, 3'd4, 1'b1);
    send_beat(1'b1, 32'h8000_0000, 32'hCAFE_F00D, 3'd5, 1'b1);
    send_beat(1'b1, 32'h7FFF_FFFF, 32'h0BAD_C0DE, 3'd6, 1'b1);
    send_beat(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7, 1'b1);
    // longer message, byte count ignored on inner words
    send_beat(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7, 1'b0);
    send_beat(1'b0, 32'hFFFF_FFFF, 32'h0, 3'd0, 1'b0);
    send_beat(1'b0, 32'h0, 32'h8000_0001, 3'd3, 1'b1);
    // message with no first mark behaves as seed zero
    send_beat(1'b0, 32'hFFFF_FFFF, 32'h0123_4567, 3'd2, 1'b0);
    send_beat(1'b0, 32'h5555_5555, 32'h89AB_CDEF, 3'd4, 1'b1);
    // first mark again in the middle restarts the message
    send_beat(1'b1, 32'h1111_1111, 32'h2222_2222, 3'd1, 1'b0);
    send_beat(1'b1, 32'h3333_3333, 32'h4444_4444, 3'd4, 1'b0);
    send_beat(1'b0, 32'h0, 32'hFFFF_FFFF, 3'd2, 1'b1);
    // last word with no valid bytes after a full word
    send_beat(1'b1, 32'h0, 32'hFFFF_FFFF, 3'd0, 1'b0);
    send_beat(1'b0, 32'h0, 32'hFFFF_FFFF, 3'd0, 1'b1);

    // random part, idling pattern changes once a hundred beats have passed since the last change
    next_change = beats_sent;
    while (beats_sent < TARGET_BEATS) begin
      if (beats_sent >= CALM_BEATS) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end else if (beats_sent >= next_change) begin
        case ($urandom_range(0, 3))
          0: send_idle_pct = 0;
          1: send_idle_pct = 5;
          2: send_idle_pct = 25;
          default: send_idle_pct = 60;
        endcase
        case ($urandom_range(0, 3))
          0: recv_stall_pct = 0;
          1: recv_stall_pct = 5;
          2: recv_stall_pct = 25;
          default: recv_stall_pct = 60;
        endcase
        next_change = beats_sent + 100;
      end
      send_message();
    end
    @(negedge clk);
    in_valid = 1'b0;

    // drain, then keep the monitor running for anything stray
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
design/c32h_pkg.sv
design/c32h_front.sv
design/c32h_queue.sv
design/c32h_back.sv
design/crc32c_byte_string_hash.sv
test/crc32c_byte_string_hash_tb.sv
